// ===== src/tdr_pkg.sv =====
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types, operation codes and helpers for the divider/timer block.
// ----------------------------------------------------------------------------
package tdr_pkg;

    // Operation codes carried with each input item.
    typedef enum logic [2:0] {
        OP_TICK          = 3'd0,
        OP_DIV_WRITE     = 3'd1,
        OP_COUNTER_WRITE = 3'd2,
        OP_MODULO_WRITE  = 3'd3,
        OP_CONTROL_WRITE = 3'd4
    } op_t;

    localparam logic [15:0] TICK_STEP    = 16'd4;
    localparam logic [1:0]  RELOAD_DELAY = 2'd2;
    localparam logic [7:0]  COUNTER_MAX  = 8'hFF;

    // System counter bit watched for each clock select code.
    localparam int unsigned SEL_BIT_0 = 9;
    localparam int unsigned SEL_BIT_1 = 3;
    localparam int unsigned SEL_BIT_2 = 5;
    localparam int unsigned SEL_BIT_3 = 7;

    // One input item as held in the input register.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       batch_end;
    } item_t;

    // One result item.
    typedef struct packed {
        logic       irq_pulse;
        logic [7:0] counter_value;
        logic [7:0] divider_value;
    } result_t;

    // Enable-gated, control-selected bit of the system counter.
    function automatic logic selected_bit(input logic [2:0] ctrl, input logic [15:0] sc);
        logic b;
        begin
            unique case (ctrl[1:0])
                2'd0:    b = sc[SEL_BIT_0];
                2'd1:    b = sc[SEL_BIT_1];
                2'd2:    b = sc[SEL_BIT_2];
                default: b = sc[SEL_BIT_3];
            endcase
            return ctrl[2] & b;
        end
    endfunction

endpackage

// ===== src/tdr_core.sv =====
// ----------------------------------------------------------------------------
// tdr_core
// Timer state registers and the combinational update for one item.
// ----------------------------------------------------------------------------
module tdr_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  tdr_pkg::item_t  item,
    output tdr_pkg::result_t result
);

    logic [15:0] sc_reg, sc_next;
    logic [7:0]  tc_reg, tc_next;
    logic [7:0]  mod_reg, mod_next;
    logic [2:0]  ctrl_reg, ctrl_next;
    logic [1:0]  cd_reg, cd_next;
    logic        prev_reg, prev_next;
    logic        armed_reg, armed_next;

    // Values seen by the edge check.
    logic [15:0] sc_edge;
    logic [2:0]  ctrl_edge;
    logic        sel_now;
    logic        fall;
    logic [1:0]  cd_dec;
    logic        irq;

    always_comb
    begin
        sc_next    = sc_reg;
        tc_next    = tc_reg;
        mod_next   = mod_reg;
        ctrl_next  = ctrl_reg;
        cd_next    = cd_reg;
        prev_next  = prev_reg;
        armed_next = armed_reg;
        irq        = 1'b0;

        // Only a tick advances the system counter; a divider write clears it.
        sc_edge   = sc_reg;
        ctrl_edge = ctrl_reg;
        unique case (item.op)
            tdr_pkg::OP_TICK:          sc_edge = sc_reg + tdr_pkg::TICK_STEP;
            tdr_pkg::OP_DIV_WRITE:     sc_edge = '0;
            tdr_pkg::OP_CONTROL_WRITE: ctrl_edge = item.data[2:0];
            default:                   ctrl_edge = ctrl_reg;
        endcase
        sel_now = tdr_pkg::selected_bit(ctrl_edge, sc_edge);
        fall    = prev_reg & ~sel_now;
        cd_dec  = (cd_reg != 2'd0) ? cd_reg - 2'd1 : 2'd0;

        unique case (item.op)
            tdr_pkg::OP_TICK:
            begin
                sc_next   = sc_edge;
                cd_next   = cd_dec;
                prev_next = sel_now;
                if (fall)
                begin
                    tc_next = tc_reg + 8'd1;
                    if (tc_reg == tdr_pkg::COUNTER_MAX)
                    begin
                        cd_next = tdr_pkg::RELOAD_DELAY;
                    end
                end
                if (cd_next == 2'd1)
                begin
                    tc_next = mod_reg;
                    irq     = 1'b1;
                end
                else if (cd_next == tdr_pkg::RELOAD_DELAY && armed_reg)
                begin
                    tc_next = mod_reg;
                    irq     = 1'b1;
                    cd_next = 2'd0;
                end
                if (item.batch_end)
                begin
                    armed_next = 1'b0;
                end
            end
            tdr_pkg::OP_DIV_WRITE, tdr_pkg::OP_CONTROL_WRITE:
            begin
                sc_next    = sc_edge;
                ctrl_next  = ctrl_edge;
                prev_next  = sel_now;
                armed_next = 1'b1;
                if (fall)
                begin
                    tc_next = tc_reg + 8'd1;
                    if (tc_reg == tdr_pkg::COUNTER_MAX)
                    begin
                        cd_next = tdr_pkg::RELOAD_DELAY;
                    end
                end
            end
            tdr_pkg::OP_COUNTER_WRITE:
            begin
                // A write in the reload cycle loses to the reload.
                if (cd_reg != 2'd1)
                begin
                    tc_next = item.data;
                    cd_next = 2'd0;
                end
            end
            tdr_pkg::OP_MODULO_WRITE:
            begin
                mod_next = item.data;
                if (cd_reg == 2'd1)
                begin
                    tc_next = item.data;
                end
            end
            default:
            begin
                irq = 1'b0;
            end
        endcase

        result.divider_value = sc_next[15:8];
        result.counter_value = tc_next;
        result.irq_pulse     = irq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg    <= '0;
            tc_reg    <= '0;
            mod_reg   <= '0;
            ctrl_reg  <= '0;
            cd_reg    <= '0;
            prev_reg  <= 1'b0;
            armed_reg <= 1'b0;
        end
        else if (step)
        begin
            sc_reg    <= sc_next;
            tc_reg    <= tc_next;
            mod_reg   <= mod_next;
            ctrl_reg  <= ctrl_next;
            cd_reg    <= cd_next;
            prev_reg  <= prev_next;
            armed_reg <= armed_next;
        end
    end

`ifndef SYNTHESIS
    a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.irq_pulse |-> item.op == tdr_pkg::OP_TICK)
        else $error("timer interrupt raised by a write");

    a_countdown_range: assert property (@(posedge clk) disable iff (!rst_n)
        cd_reg != 2'd3)
        else $error("reload countdown out of range");

    a_irq_loads_modulo: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.irq_pulse |=> tc_reg == mod_reg)
        else $error("interrupt without modulo reload");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(sc_reg) && $stable(tc_reg) && $stable(cd_reg))
        else $error("timer state changed without an item");
`endif

endmodule

// ===== src/divider_timer_with_delayed_reload.sv =====
// ----------------------------------------------------------------------------
// divider_timer_with_delayed_reload
// Divider/timer with modulo reload delayed after counter overflow.
// ----------------------------------------------------------------------------
// Each transfer on the input stream is one machine-cycle tick or one write to
// the divider, counter, modulo or control register, and it produces exactly
// one output transfer with the divider byte, the counter value and an
// interrupt flag. The block takes one transfer every clock cycle while the output
// side is ready: an input register holds the item, combinational logic applies
// it to the timer state, and a result register presents the outcome, so each
// item passes through both registers on its way to the output. The state update
// loop sustains one item per cycle. Back-pressure on the output holds the result
// register and the input register, and the input stays ready whenever either
// can move.
// ----------------------------------------------------------------------------
module divider_timer_with_delayed_reload (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    input  logic        s_axis_tlast,   // batch_end
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] divider_value, [15:8] counter_value
    output logic        m_axis_tuser    // irq_pulse
);

    tdr_pkg::item_t   in_reg;
    logic             in_valid_reg;
    tdr_pkg::result_t res_comb;
    tdr_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;

    // The held item moves into the result register when that register is
    // empty or its current result is being taken in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.op        <= s_axis_tuser;
            in_reg.data      <= s_axis_tdata;
            in_reg.batch_end <= s_axis_tlast;
        end
        if (advance)
        begin
            out_reg <= res_comb;
        end
    end

    tdr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_reg),
        .result (res_comb)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.counter_value, out_reg.divider_value};
    assign m_axis_tuser  = out_reg.irq_pulse;

`ifndef SYNTHESIS
    a_no_drop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(m_axis_tdata))
        else $error("stalled result was lost or changed");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item did not reach the result register");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

// ===== dv/divider_timer_with_delayed_reload_tb.sv =====
// ----------------------------------------------------------------------------
// divider_timer_with_delayed_reload_tb
// Self-checking testbench for the divider/timer with delayed modulo reload.
// ----------------------------------------------------------------------------
// A queue of ticks and register writes is built up front: a short directed
// opening that walks through overflow by tick and by write, the dropped and
// redirected writes while the reload is pending, the early reload, and the
// unused operation codes, followed by random overflow-seeking sequences mixed
// with noise. A clocked driver feeds the input stream from that queue, and a
// clocked monitor predicts each accepted transfer in order and compares every
// output transfer with the oldest prediction. Both stream sides idle in short
// random bursts, the receiver holds off for long stretches, and the sender
// pauses at times until every outstanding result has come back.
// ----------------------------------------------------------------------------
module divider_timer_with_delayed_reload_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes that the block does not decode.
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    // Clock select codes in the control register, named after the input
    // clock division they give on the original hardware.
    localparam logic [1:0] CLK_SEL_1024 = 2'd0;
    localparam logic [1:0] CLK_SEL_16   = 2'd1;
    localparam logic [1:0] CLK_SEL_64   = 2'd2;
    localparam logic [1:0] CLK_SEL_256  = 2'd3;

    localparam int RANDOM_ITEMS     = 1700;
    localparam int TAIL_ITEMS       = 150;   // no idling once this few are left
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int LONG_HOLD_COUNT  = 2;
    localparam int DRAIN_CYCLES     = 10;
    localparam int IDLE_LIMIT       = 5000;
    localparam int MAX_REPORTS      = 10;

    // One pending input transfer. drain_first makes the driver wait until
    // every outstanding result has been received before offering it.
    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } timer_item_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [2:0]  s_axis_tuser = tdr_pkg::OP_TICK;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    always #5 clk = ~clk;

    divider_timer_with_delayed_reload uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // Stimulus and scoreboard storage.
    // ------------------------------------------------------------------------
    timer_item_t      pending_items[$];
    tdr_pkg::result_t expected_results[$];
    int               total_items = 0;
    int               items_accepted = 0;
    int               results_seen = 0;
    int               stim_count = 0;
    bit               drain_next = 1'b0;
    int               errors = 0;
    bit               in_taken = 1'b0;

    // Coverage-style tallies for the closing summary.
    int ticks_seen = 0;
    int writes_seen = 0;
    int irq_count = 0;
    int early_reloads = 0;
    int write_overflows = 0;
    int dropped_counter_writes = 0;

    // ------------------------------------------------------------------------
    // Timer model state, updated in the order items are accepted.
    // ------------------------------------------------------------------------
    logic [15:0] sys_count = '0;
    logic [7:0]  timer_count = '0;
    logic [7:0]  modulo_reg = '0;
    logic [2:0]  ctrl_bits = '0;
    logic [1:0]  reload_cnt = '0;
    logic        prev_watched = 1'b0;
    logic        early_armed = 1'b0;

    // The divider bit that clocks the timer, forced low when disabled.
    function automatic logic watched_bit(logic [2:0] ctrl, logic [15:0] sc);
        int unsigned pos;
        unique case (ctrl[1:0])
            CLK_SEL_1024: pos = tdr_pkg::SEL_BIT_0;
            CLK_SEL_16:   pos = tdr_pkg::SEL_BIT_1;
            CLK_SEL_64:   pos = tdr_pkg::SEL_BIT_2;
            default:      pos = tdr_pkg::SEL_BIT_3;
        endcase
        return ctrl[2] & sc[pos];
    endfunction

    // Falling-edge detector on the watched bit. Returns 1 when the counter
    // wrapped and the reload countdown was started.
    function automatic bit timer_edge_check();
        logic now_bit;
        bit   wrapped;
        now_bit = watched_bit(ctrl_bits, sys_count);
        wrapped = 1'b0;
        if (prev_watched && !now_bit)
        begin
            if (timer_count == tdr_pkg::COUNTER_MAX)
            begin
                timer_count = 8'h00;
                reload_cnt  = tdr_pkg::RELOAD_DELAY;
                wrapped     = 1'b1;
            end
            else
            begin
                timer_count = timer_count + 8'd1;
            end
        end
        prev_watched = now_bit;
        return wrapped;
    endfunction

    // Applies one item to the model and returns the result it should give.
    function automatic tdr_pkg::result_t timer_predict(logic [2:0] op, logic [7:0] data,
                                                       logic last);
        tdr_pkg::result_t r;
        bit               wrapped;
        r.irq_pulse = 1'b0;
        unique case (op)
            tdr_pkg::OP_TICK:
            begin
                sys_count = sys_count + tdr_pkg::TICK_STEP;
                if (reload_cnt != 2'd0)
                    reload_cnt = reload_cnt - 2'd1;
                wrapped = timer_edge_check();
                // Last cycle of the countdown: the normal delayed reload.
                if (reload_cnt == 2'd1)
                begin
                    timer_count = modulo_reg;
                    r.irq_pulse = 1'b1;
                end
                // Overflow on this very tick while a divider or control write
                // is still armed: the reload happens at once.
                if (reload_cnt == tdr_pkg::RELOAD_DELAY && early_armed)
                begin
                    timer_count = modulo_reg;
                    r.irq_pulse = 1'b1;
                    reload_cnt  = 2'd0;
                    early_reloads++;
                end
                if (last)
                    early_armed = 1'b0;
            end
            tdr_pkg::OP_DIV_WRITE:
            begin
                sys_count = '0;
                wrapped = timer_edge_check();
                if (wrapped)
                    write_overflows++;
                early_armed = 1'b1;
            end
            tdr_pkg::OP_COUNTER_WRITE:
            begin
                // A write in the reload cycle loses against the reload.
                if (reload_cnt != 2'd1)
                begin
                    timer_count = data;
                    reload_cnt  = 2'd0;
                end
                else
                begin
                    dropped_counter_writes++;
                end
            end
            tdr_pkg::OP_MODULO_WRITE:
            begin
                modulo_reg = data;
                if (reload_cnt == 2'd1)
                    timer_count = data;
            end
            tdr_pkg::OP_CONTROL_WRITE:
            begin
                ctrl_bits = data[2:0];
                wrapped = timer_edge_check();
                if (wrapped)
                    write_overflows++;
                early_armed = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.divider_value = sys_count[15:8];
        r.counter_value = timer_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_item(logic [2:0] op, logic [7:0] data, logic last);
        timer_item_t it;
        it.op          = op;
        it.data        = data;
        it.last        = last;
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        pending_items.push_back(it);
        stim_count++;
    endtask

    // Control byte with random upper bits, which the block must drop.
    function automatic logic [7:0] ctrl_byte(logic enable, logic [1:0] sel);
        logic [7:0] b;
        b      = 8'($urandom_range(0, 255));
        b[2]   = enable;
        b[1:0] = sel;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents items at the falling edge. An item stays on the bus
    // until the monitor has seen it accepted at a rising edge.
    // ------------------------------------------------------------------------
    int tx_gap = 0;

    always @(negedge clk)
    begin : driver
        timer_item_t it;
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
            begin
                // Still waiting for the current transfer to be taken.
            end
            else if (tx_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (pending_items.size() == 0 ||
                     (pending_items[0].drain_first &&
                      expected_results.size() != 0))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > TAIL_ITEMS &&
                     $urandom_range(0, 7) == 0)
            begin
                // Start an idle burst.
                s_axis_tvalid <= 1'b0;
                tx_gap <= $urandom_range(0, 6);
            end
            else
            begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.op;
                s_axis_tdata  <= it.data;
                s_axis_tlast  <= it.last;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure: short random stalls, plus a couple of long
    // hold-offs so the pipeline fills up and the input side has to stall.
    // ------------------------------------------------------------------------
    int hold_left = 0;
    int long_holds = 0;
    int long_hold_at = 300;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (long_holds < LONG_HOLD_COUNT && results_seen >= long_hold_at)
            begin
                m_axis_tready <= 1'b0;
                hold_left <= LONG_HOLD_CYCLES - 1;
                long_holds <= long_holds + 1;
                long_hold_at <= long_hold_at + 700;
            end
            else if (pending_items.size() > TAIL_ITEMS &&
                     $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left <= $urandom_range(0, 6);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts every accepted input transfer and checks every output
    // transfer against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        tdr_pkg::result_t want;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_accepted++;
                if (s_axis_tuser == tdr_pkg::OP_TICK)
                    ticks_seen++;
                else if (s_axis_tuser < OP_FIRST_UNUSED)
                    writes_seen++;
                expected_results.push_back(
                    timer_predict(s_axis_tuser, s_axis_tdata, s_axis_tlast));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser === 1'b1)
                    irq_count++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%t: result with nothing expected: tdata %04h tuser %b",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[7:0] !== want.divider_value ||
                        m_axis_tdata[15:8] !== want.counter_value ||
                        m_axis_tuser !== want.irq_pulse)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%t: result %0d mismatch (exp/got): ",
                                      "div %02h/%02h cnt %02h/%02h irq %b/%b"},
                                     $realtime, results_seen,
                                     want.divider_value, m_axis_tdata[7:0],
                                     want.counter_value, m_axis_tdata[15:8],
                                     want.irq_pulse, m_axis_tuser);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no transfer happens on either side for too
    // long. The longest legal quiet stretch is a receiver hold-off.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence: build the stimulus, reset, wait for completion, report.
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        int         directed_count;
        int         seg;
        int         n;
        logic [1:0] sel;
        logic [2:0] op;

        // Directed opening. The counter is driven to its top value and the
        // watched bit is dropped by a control write, so the overflow comes
        // from the write itself.
        add_item(tdr_pkg::OP_MODULO_WRITE, 8'hFF, 1'b1);
        add_item(tdr_pkg::OP_MODULO_WRITE, 8'hA5, 1'b0);
        add_item(tdr_pkg::OP_DIV_WRITE, 8'hFF, 1'b0);
        add_item(tdr_pkg::OP_COUNTER_WRITE, tdr_pkg::COUNTER_MAX, 1'b0);
        add_item(tdr_pkg::OP_CONTROL_WRITE, 8'hF8 | ctrl_byte(1'b1, CLK_SEL_16), 1'b0);
        add_item(tdr_pkg::OP_TICK, 8'h00, 1'b0);
        add_item(tdr_pkg::OP_TICK, 8'hFF, 1'b0);
        add_item(tdr_pkg::OP_CONTROL_WRITE, ctrl_byte(1'b0, CLK_SEL_16), 1'b0);
        // The next tick ends the countdown and reloads. While the countdown
        // sits at one, a counter write is dropped and a modulo write also
        // lands in the counter.
        add_item(tdr_pkg::OP_TICK, 8'h00, 1'b0);
        add_item(tdr_pkg::OP_COUNTER_WRITE, 8'h33, 1'b0);
        add_item(tdr_pkg::OP_MODULO_WRITE, 8'h5A, 1'b0);
        add_item(tdr_pkg::OP_TICK, 8'h00, 1'b1);
        // Early reload: a divider write arms it, and the overflow on the
        // fourth tick reloads at once instead of after the countdown.
        add_item(tdr_pkg::OP_DIV_WRITE, 8'h00, 1'b0);
        add_item(tdr_pkg::OP_COUNTER_WRITE, tdr_pkg::COUNTER_MAX, 1'b0);
        add_item(tdr_pkg::OP_CONTROL_WRITE, ctrl_byte(1'b1, CLK_SEL_16), 1'b0);
        repeat (4) add_item(tdr_pkg::OP_TICK, 8'h00, 1'b0);
        add_item(tdr_pkg::OP_TICK, 8'hFF, 1'b1);
        // Unused codes must leave the state alone.
        add_item(OP_FIRST_UNUSED, 8'hFF, 1'b1);
        add_item(OP_FIRST_UNUSED + 3'd1, 8'h00, 1'b0);
        add_item(OP_LAST_UNUSED, 8'hFF, 1'b1);
        add_item(tdr_pkg::OP_CONTROL_WRITE, 8'h07, 1'b1);
        add_item(tdr_pkg::OP_COUNTER_WRITE, 8'h00, 1'b1);
        add_item(tdr_pkg::OP_TICK, 8'h00, 1'b1);
        directed_count = stim_count;

        // Random part. Most segments load the counter near its top value and
        // pick a clock select, then run ticks with writes sprinkled in so the
        // overflow and reload window is hit with all kinds of traffic.
        seg = 0;
        while (stim_count - directed_count < RANDOM_ITEMS)
        begin
            if (seg % 40 == 0)
                drain_next = 1'b1;
            seg++;
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 2) == 0)
                    add_item(tdr_pkg::OP_DIV_WRITE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                add_item(tdr_pkg::OP_COUNTER_WRITE,
                         tdr_pkg::COUNTER_MAX - 8'($urandom_range(0, 4)),
                         1'($urandom_range(0, 1)));
                sel = ($urandom_range(0, 9) < 6) ? CLK_SEL_16 : 2'($urandom_range(0, 3));
                add_item(tdr_pkg::OP_CONTROL_WRITE,
                         ctrl_byte($urandom_range(0, 9) != 0, sel),
                         1'($urandom_range(0, 1)));
                n = $urandom_range(8, 48);
                repeat (n)
                begin
                    if ($urandom_range(0, 6) == 0)
                        add_item(3'($urandom_range(tdr_pkg::OP_DIV_WRITE,
                                                   tdr_pkg::OP_CONTROL_WRITE)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    else
                        add_item(tdr_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                                 $urandom_range(0, 3) == 0);
                end
            end
            else
            begin
                n = $urandom_range(4, 16);
                repeat (n)
                begin
                    op = 3'($urandom_range(0, 7));
                    add_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end
        total_items = pending_items.size();

        // Hold reset, then release it at a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every item accepted and every result back, then a short tail to
        // catch stray output transfers.
        wait (items_accepted == total_items && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d ticks and %0d register writes of %0d items; %0d interrupts.",
                 ticks_seen, writes_seen, total_items, irq_count);
        $display("Early reloads %0d, write overflows %0d, dropped counter writes %0d.",
                 early_reloads, write_overflows, dropped_counter_writes);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results still expected",
                     errors, expected_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
